// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the Fresnel sine series block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fss_pkg.sv =====
// ----------------------------------------------------------------------------
// fss_pkg
// Types, fixed-point constants and helper functions for the Fresnel sine
// integral series pipeline.
// ----------------------------------------------------------------------------
package fss_pkg;

  // Default number of series terms after x^3/3
  localparam int unsigned TERMS_DEF = 20;

  // Coefficient format: unsigned Q0.55
  localparam int unsigned COEF_FRAC = 55;

  // Field widths
  localparam int unsigned ARG_W = 32;
  localparam int unsigned OUT_W = 49;

  typedef logic [62:0]        mag_t;   // term magnitude, unsigned Q18.46
  typedef logic signed [63:0] acc_t;   // running sum, signed Q18.46
  typedef logic [63:0]        x4_t;    // x^4, unsigned Q8.56
  typedef logic signed [48:0] out_t;   // result, signed Q2.46

  // One transaction as it moves from term to term
  typedef struct packed {
    logic valid;
    mag_t mag;
    acc_t acc;
    x4_t  x4;
  } chain_t;

  localparam mag_t MAG_MAX = '1;
  localparam acc_t ACC_MAX = {1'b0, {63{1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, 63'b0};
  localparam out_t OUT_MAX = {1'b0, {48{1'b1}}};
  localparam out_t OUT_MIN = {1'b1, 48'b0};

  // Rounding offsets added to each full product before the shift
  localparam logic [127:0] X4_BIAS   = 128'd1 << 63;                  // x2*x2 >> 64
  localparam logic [127:0] X3P1_BIAS = (128'd1 << 43) + (128'd1 << 44); // x3 + 1
  localparam logic [127:0] DIV3_BIAS = 128'd0;                        // floor
  localparam logic [127:0] COEF_BIAS = 128'd1 << 54;                  // >> 55
  localparam logic [127:0] TERM_BIAS = 128'd1 << 55;                  // >> 56

  // Reciprocal of 3 in Q0.55, exact floor for dividends below 2^55
  localparam logic [63:0] RECIP3 = ((64'd1 << 55) + 64'd1) / 64'd3;

  // Signed add of a magnitude with saturation to the 64-bit range
  function automatic acc_t sat_add(acc_t acc, mag_t mag, logic neg);
    logic [64:0] s;
    if (neg) begin
      s = {acc[63], acc} - {2'b00, mag};
    end else begin
      s = {acc[63], acc} + {2'b00, mag};
    end
    if (s[64] != s[63]) begin
      return s[64] ? ACC_MIN : ACC_MAX;
    end
    return acc_t'(s[63:0]);
  endfunction

  // Saturate the Q18.46 sum to Q2.46
  function automatic out_t clamp_out(acc_t acc);
    if (acc[63:48] == {16{acc[63]}}) begin
      return out_t'(acc[48:0]);
    end
    return acc[63] ? OUT_MIN : OUT_MAX;
  endfunction

endpackage

// ===== rtl/fresnel_sine_series.sv =====
// ----------------------------------------------------------------------------
// fresnel_sine_series
// Fresnel sine integral S(x) by truncated Maclaurin series, fully
// pipelined: front end, one four-stage section per term, final sum.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake             | Payload
//  --------+-----------------------+-----------------------------------------
//  input   | in_valid / in_ready   | arg [31:0], x in unsigned Q2.30
//  output  | out_valid / out_ready | sine_integral [48:0], S(x) signed Q2.46
//
//  One transaction per cycle sustained while the output buffer is not full.
//  Each term holds two 64x64 multiplies,
//  each split into a partial-product stage and a summing stage.
//  Reset clears only valid bits and buffer occupancy; no clearing pass.
//  The whole pipeline freezes only when both output buffer entries are
//  waiting; in_ready is low exactly then.
//
module fresnel_sine_series #(
  parameter int unsigned TERMS = fss_pkg::TERMS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [31:0]         arg,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [48:0]  sine_integral
);

  localparam logic FINAL_NEG = (TERMS % 2) == 1;

  logic            en;
  logic            full;
  logic            vf;
  fss_pkg::acc_t   accf;
  fss_pkg::chain_t chain [TERMS + 1];

  // Pipeline advances unless the output buffer is full
  assign en       = ~full;
  assign in_ready = en;

  fss_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .arg      (arg),
    .out_bus  (chain[0])
  );

  // One section per term, coefficient fixed at elaboration
  for (genvar g = 1; g <= TERMS; g++) begin : g_term
    localparam logic [63:0] CNUM = 64'(4 * g - 1) << fss_pkg::COEF_FRAC;
    localparam logic [63:0] CDEN = 64'(2 * g) * 64'(2 * g + 1) * 64'(4 * g + 3);
    localparam logic [63:0] CVAL = (CNUM + CDEN / 64'd2) / CDEN;
    localparam logic        PREV_NEG = ((g - 1) % 2) == 1;

    fss_term u_term (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .coef    (CVAL),
      .add_neg (PREV_NEG),
      .in_bus  (chain[g - 1]),
      .out_bus (chain[g])
    );
  end

  // Final stage: add the last term
  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else if (en) begin
      vf <= chain[TERMS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      accf <= fss_pkg::sat_add(chain[TERMS].acc, chain[TERMS].mag, FINAL_NEG);
    end
  end

  // Clamp to Q2.46 on the way into the output buffer
  fss_outbuf u_outbuf (
    .clk   (clk),
    .rst   (rst),
    .push  (en & vf),
    .din   (fss_pkg::clamp_out(accf)),
    .take  (out_ready),
    .full  (full),
    .valid (out_valid),
    .dout  (sine_integral)
  );

endmodule

// ===== rtl/fss_mul.sv =====
// ----------------------------------------------------------------------------
// fss_mul
// Two-stage 64x64 unsigned multiplier: four 32x32 partial products, then
// the summing add with a rounding offset. Full 128-bit product out.
// ----------------------------------------------------------------------------
module fss_mul (
  input  logic         clk,
  input  logic         en,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  input  logic [127:0] bias,
  output logic [127:0] prod
);

  logic [63:0] pp00;
  logic [63:0] pp01;
  logic [63:0] pp10;
  logic [63:0] pp11;

  // Stage 1: partial products
  always_ff @(posedge clk) begin
    if (en) begin
      pp00 <= 64'(a[31:0])  * 64'(b[31:0]);
      pp01 <= 64'(a[31:0])  * 64'(b[63:32]);
      pp10 <= 64'(a[63:32]) * 64'(b[31:0]);
      pp11 <= 64'(a[63:32]) * 64'(b[63:32]);
    end
  end

  // Stage 2: combine, add rounding offset
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= {pp11, pp00} + (128'(pp01) << 32) + (128'(pp10) << 32) + bias;
    end
  end

endmodule

// ===== rtl/fss_front.sv =====
// ----------------------------------------------------------------------------
// fss_front
// Front end: x^2, then x^4 and x^3 in parallel, then x^3/3 by reciprocal
// multiply. Produces the first term and x^4 for the term chain.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fss_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [31:0]         arg,
  output fss_pkg::chain_t     out_bus
);

  logic         v1, v2, v3, v4, v5;
  logic [31:0]  x1;
  logic [63:0]  x2;
  logic [127:0] p4;
  logic [127:0] p3;
  logic [127:0] pd;
  fss_pkg::x4_t x4_4;
  fss_pkg::x4_t x4_5;

  // Valid bits follow the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // Stage 1: x^2 exact in Q4.60
  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= arg;
      x2 <= 64'(arg) * 64'(arg);
    end
  end

  // Stages 2-3: x^4 rounded to Q8.56, x^3 + 1 in Q18.46
  fss_mul u_x4 (
    .clk  (clk),
    .en   (en),
    .a    (x2),
    .b    (x2),
    .bias (fss_pkg::X4_BIAS),
    .prod (p4)
  );

  fss_mul u_x3 (
    .clk  (clk),
    .en   (en),
    .a    (x2),
    .b    ({32'b0, x1}),
    .bias (fss_pkg::X3P1_BIAS),
    .prod (p3)
  );

  // Stages 4-5: (x^3 + 1) / 3 as multiply by reciprocal, floor
  fss_mul u_div3 (
    .clk  (clk),
    .en   (en),
    .a    ({11'b0, p3[96:44]}),
    .b    (fss_pkg::RECIP3),
    .bias (fss_pkg::DIV3_BIAS),
    .prod (pd)
  );

  // x^4 rides along with the divide
  always_ff @(posedge clk) begin
    if (en) begin
      x4_4 <= p4[127:64];
      x4_5 <= x4_4;
    end
  end

  assign out_bus.valid = v5;
  assign out_bus.mag   = pd[fss_pkg::COEF_FRAC + 62:fss_pkg::COEF_FRAC];
  assign out_bus.acc   = '0;
  assign out_bus.x4    = x4_5;

  // x^3/3 stays far below the magnitude limit
  `ASSERT_IMPLIES(a_first_term_range, clk, rst, v5, pd[117:107] == '0,
    "first term out of range")

endmodule

// ===== rtl/fss_term.sv =====
// ----------------------------------------------------------------------------
// fss_term
// One series term: magnitude times coefficient, times x^4, saturated.
// The previous term is folded into the running sum in the first stage.
// ----------------------------------------------------------------------------
module fss_term (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic [63:0]     coef,
  input  logic            add_neg,
  input  fss_pkg::chain_t in_bus,
  output fss_pkg::chain_t out_bus
);

  logic          v1, v2, v3, v4;
  fss_pkg::acc_t acc1, acc2, acc3, acc4;
  fss_pkg::x4_t  x4_1, x4_2, x4_3, x4_4;
  logic [127:0]  prod_c;
  logic [127:0]  prod_x;
  logic [71:0]   rnd;

  // Valid bits follow the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_bus.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Accumulate previous term, carry sum and x^4 along
  always_ff @(posedge clk) begin
    if (en) begin
      acc1 <= fss_pkg::sat_add(in_bus.acc, in_bus.mag, add_neg);
      acc2 <= acc1;
      acc3 <= acc2;
      acc4 <= acc3;
      x4_1 <= in_bus.x4;
      x4_2 <= x4_1;
      x4_3 <= x4_2;
      x4_4 <= x4_3;
    end
  end

  // Stages 1-2: magnitude times coefficient, rounded to Q18.46
  fss_mul u_coef (
    .clk  (clk),
    .en   (en),
    .a    ({1'b0, in_bus.mag}),
    .b    (coef),
    .bias (fss_pkg::COEF_BIAS),
    .prod (prod_c)
  );

  // Stages 3-4: times x^4, rounded to Q18.46
  fss_mul u_pow (
    .clk  (clk),
    .en   (en),
    .a    (prod_c[fss_pkg::COEF_FRAC + 63:fss_pkg::COEF_FRAC]),
    .b    (x4_2),
    .bias (fss_pkg::TERM_BIAS),
    .prod (prod_x)
  );

  // Saturate the new magnitude
  assign rnd = prod_x[127:56];

  assign out_bus.valid = v4;
  assign out_bus.mag   = (|rnd[71:63]) ? fss_pkg::MAG_MAX : rnd[62:0];
  assign out_bus.acc   = acc4;
  assign out_bus.x4    = x4_4;

endmodule

// ===== rtl/fss_outbuf.sv =====
// ----------------------------------------------------------------------------
// fss_outbuf
// Two-entry output buffer: head drives the output port, spare absorbs
// one more result so the pipeline keeps moving while the head waits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fss_outbuf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  fss_pkg::out_t din,
  input  logic          take,
  output logic          full,
  output logic          valid,
  output fss_pkg::out_t dout
);

  logic          head_vld;
  logic          head_vld_next;
  logic          spare_vld;
  logic          spare_vld_next;
  fss_pkg::out_t head_data;
  fss_pkg::out_t head_data_next;
  fss_pkg::out_t spare_data;
  fss_pkg::out_t spare_data_next;
  logic          pop;

  assign pop   = head_vld & take;
  assign full  = spare_vld;
  assign valid = head_vld;
  assign dout  = head_data;

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      head_vld  <= 1'b0;
      spare_vld <= 1'b0;
    end else begin
      head_vld  <= head_vld_next;
      spare_vld <= spare_vld_next;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    head_data  <= head_data_next;
    spare_data <= spare_data_next;
  end

  // Next-state: pop moves spare to head, push fills the first free slot
  always_comb begin
    head_vld_next   = head_vld;
    spare_vld_next  = spare_vld;
    head_data_next  = head_data;
    spare_data_next = spare_data;
    if (pop) begin
      if (spare_vld) begin
        head_data_next = spare_data;
        if (push) begin
          spare_data_next = din;
        end else begin
          spare_vld_next = 1'b0;
        end
      end else if (push) begin
        head_data_next = din;
      end else begin
        head_vld_next = 1'b0;
      end
    end else if (push) begin
      if (head_vld) begin
        spare_data_next = din;
        spare_vld_next  = 1'b1;
      end else begin
        head_data_next = din;
        head_vld_next  = 1'b1;
      end
    end
  end

  `ASSERT_IMPLIES(a_spare_needs_head, clk, rst, spare_vld, head_vld,
    "spare entry held without head entry")
  `ASSERT_IMPLIES(a_no_push_when_full, clk, rst, push, !spare_vld,
    "result pushed into full buffer")
  `ASSERT_NEXT(a_spare_promoted, clk, rst, pop && spare_vld, head_vld,
    "spare entry lost on pop")

endmodule

// ===== bench/tb_fresnel_sine_series.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fresnel_sine_series
// Self-checking bench for the Fresnel sine integral series pipeline. A local
// fixed-point model of the series predicts every result. Test tasks drive
// directed arguments, random arguments with and without idle cycles, and a
// long output hold that fills the pipeline and stalls the input.
// ----------------------------------------------------------------------------
module tb_fresnel_sine_series;

  localparam int unsigned TERMS   = fss_pkg::TERMS_DEF;
  localparam int unsigned LATENCY = 4 * TERMS + 6;

  // Q18.46 magnitude ceiling and Q2.46 output range
  localparam logic [63:0]        MAG_CEIL = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] Q246_MAX = 64'sd281474976710655;
  localparam logic signed [63:0] Q246_MIN = -64'sd281474976710656;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [fss_pkg::ARG_W-1:0] arg = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [fss_pkg::OUT_W-1:0] sine_integral;

  // Predicted sums in acceptance order
  logic signed [fss_pkg::OUT_W-1:0] expected_sums[$];
  int mismatches = 0;

  // Idle controls shared by sender, receiver and tests
  bit arg_gaps_on    = 1'b0;
  bit result_stalls_on = 1'b0;
  int result_hold_cycles = 0;

  fresnel_sine_series #(
    .TERMS(TERMS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .arg(arg),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sine_integral(sine_integral)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Series model
  // ---------------------------------------------------------------------------

  // (a*b) / 2^s rounded to nearest, saturated to 64 bits
  function automatic logic [63:0] round_shift(logic [63:0] a, logic [63:0] b,
                                              int unsigned s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p + (128'd1 << (s - 1));
    p = p >> s;
    return (p[127:64] != 0) ? '1 : p[63:0];
  endfunction

  // (4n-1)/(2n(2n+1)(4n+3)) in unsigned Q0.55, rounded to nearest
  function automatic logic [63:0] term_ratio(int unsigned n);
    logic [63:0] nn, den, num;
    nn  = 64'(n);
    den = (2 * nn) * (2 * nn + 1) * (4 * nn + 3);
    num = (4 * nn - 1) << fss_pkg::COEF_FRAC;
    return (num + den / 2) / den;
  endfunction

  function automatic logic signed [fss_pkg::OUT_W-1:0]
      predict_sine_integral(logic [31:0] x);
    logic [63:0] x2, x3, x4, mag;
    logic signed [63:0] sum;
    logic signed [64:0] wide;
    logic neg;
    x2  = {32'd0, x} * {32'd0, x};
    x4  = round_shift(x2, x2, 64);
    x3  = round_shift(x2, {32'd0, x}, 44);
    mag = (x3 + 64'd1) / 64'd3;
    if (mag > MAG_CEIL) mag = MAG_CEIL;
    sum = $signed(mag);
    neg = 1'b0;
    for (int unsigned n = 1; n <= TERMS; n++) begin
      mag = round_shift(mag, term_ratio(n), fss_pkg::COEF_FRAC);
      mag = round_shift(mag, x4, 56);
      if (mag > MAG_CEIL) mag = MAG_CEIL;
      neg = !neg;
      // 65-bit add, then saturate to the 64-bit accumulator
      wide = {sum[63], sum};
      if (neg) wide = wide - $signed({1'b0, mag});
      else     wide = wide + $signed({1'b0, mag});
      if (wide[64] != wide[63]) sum = wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      else                      sum = wide[63:0];
    end
    if (sum > Q246_MAX) sum = Q246_MAX;
    if (sum < Q246_MIN) sum = Q246_MIN;
    return sum[48:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Shared sender and drain
  // ---------------------------------------------------------------------------

  // Offer one argument, hold it until accepted, record its prediction
  task automatic send_arg(input logic [31:0] x);
    int gap;
    gap = arg_gaps_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    arg      <= x;
    do @(posedge clk); while (!in_ready);
    expected_sums.push_back(predict_sine_integral(x));
  endtask

  // Stop offering and wait until every prediction has been matched
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Random argument, weighted toward both ends of the range
  function automatic logic [31:0] pick_arg();
    int sel;
    sel = $urandom_range(0, 3);
    case (sel)
      0: begin
        return 32'(3) << 30 | 32'($urandom_range(0, 32'h3FFF_FFFF));
      end
      1: begin
        return 32'($urandom_range(0, 32'h00FF_FFFF));
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, or a long hold when a test asks for one
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (result_hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (result_hold_cycles) @(posedge clk);
        result_hold_cycles = 0;
      end else begin
        stall = result_stalls_on ? $urandom_range(0, 3) : 0;
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ready <= 1'b1;
        do @(posedge clk); while (!out_valid && result_hold_cycles == 0);
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    logic signed [fss_pkg::OUT_W-1:0] want;
    if (!rst && out_valid && out_ready) begin
      if (expected_sums.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result transaction, actual %h", $time, sine_integral);
      end else begin
        want = expected_sums.pop_front();
        if (sine_integral !== want) begin
          mismatches++;
          $display("%0t: sine_integral mismatch, expected %h actual %h",
                   $time, want, sine_integral);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Range ends, integer points, bit patterns and the large-term region
  task automatic test_directed();
    logic [31:0] args[] = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002,
                            32'h0000_0100, 32'h0010_0000, 32'h2000_0000,
                            32'h4000_0000, 32'h6000_0000, 32'h7FFF_FFFF,
                            32'h8000_0000, 32'hA000_0000, 32'hC000_0000,
                            32'hE000_0000, 32'hF000_0000, 32'hF800_0000,
                            32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h5555_5555,
                            32'hAAAA_AAAA, 32'hE6A0_9E66};
    arg_gaps_on      = 1'b0;
    result_stalls_on = 1'b0;
    foreach (args[i]) send_arg(args[i]);
    wait_for_results();
  endtask

  // Full-range arguments with idle cycles on both sides
  task automatic test_random_idle();
    arg_gaps_on      = 1'b1;
    result_stalls_on = 1'b1;
    repeat (300) send_arg($urandom);
    wait_for_results();
  endtask

  // Back-to-back traffic, no idling anywhere
  task automatic test_streaming();
    arg_gaps_on      = 1'b0;
    result_stalls_on = 1'b0;
    repeat (150) send_arg(pick_arg());
    wait_for_results();
  endtask

  // Long output hold so the pipeline fills and stops taking arguments
  task automatic test_backpressure();
    arg_gaps_on        = 1'b0;
    result_stalls_on   = 1'b0;
    result_hold_cycles = 400;
    repeat (200) send_arg(pick_arg());
    wait_for_results();
  endtask

  // Weighted arguments, idling on the input side, then the output side, then both
  task automatic test_random_mix();
    arg_gaps_on      = 1'b1;
    result_stalls_on = 1'b0;
    repeat (100) send_arg(pick_arg());
    arg_gaps_on      = 1'b0;
    result_stalls_on = 1'b1;
    repeat (100) send_arg(pick_arg());
    arg_gaps_on      = 1'b1;
    repeat (100) send_arg(pick_arg());
    wait_for_results();
  endtask

  // Main sequence
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_idle();
    test_streaming();
    test_backpressure();
    test_random_mix();
    if (mismatches == 0 && expected_sums.size() == 0) begin
      $display("fresnel_sine_series regression: pass");
    end else begin
      $display("fresnel_sine_series regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("fresnel_sine_series regression: fail");
    $finish;
  end

endmodule
